// ===== hw/rtl/vdn_pkg.sv =====
// Package for the vector distance block: widths, codes and shared types.
// Used by every module under hw/rtl.
package vdn_pkg;

    localparam int ELEM_W    = 16;   // Q8.8 element
    localparam int ABS_W     = 16;   // |x - y|, at most 65535
    localparam int SQ_W      = 32;   // (x - y)^2
    localparam int ABS_SUM_W = 24;
    localparam int SQ_SUM_W  = 40;
    localparam int CNT_W     = 9;
    localparam int DIST_W    = 24;
    localparam int OPND_W    = SQ_SUM_W;
    localparam int BIT_W     = 39;   // one-hot trial bit of the root unit

    localparam int MAX_LENGTH = 256;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(MAX_LENGTH < 511 ? MAX_LENGTH : 511);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;
    // headroom kept free for the last-pairs still in the front pipeline
    localparam logic [QCNT_W-1:0] QROOM_MAX = QCNT_W'(QDEPTH - 3);

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    localparam logic [1:0] NORM_L1   = 2'd0;
    localparam logic [1:0] NORM_L2   = 2'd1;
    localparam logic [1:0] NORM_LINF = 2'd2;
    localparam logic [1:0] NORM_RSVD = 2'd3;

    typedef struct packed {
        logic              is_root;   // operand needs the square root
        logic [OPND_W-1:0] operand;
        logic [CNT_W-1:0]  count;
    } job_t;

    typedef struct packed {
        logic              empty;
        logic              room;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

// ===== hw/rtl/vdn_front.sv =====
// Front end: accepts element pairs, forms |x - y| and its square, keeps the
// running sums and pushes one job per vector into the queue. Uses vdn_pkg.
module vdn_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [1:0]                    norm_select,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vdn_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  vdn_pkg::q_stat_t              q_stat,
    output logic                          push,
    output vdn_pkg::job_t                 push_job
);
    import vdn_pkg::*;

    logic                 s1_valid_reg, s2_valid_reg;
    logic                 s1_last_reg, s2_last_reg;
    logic [ABS_W-1:0]     s1_abs_reg, s2_abs_reg;
    logic [SQ_W-1:0]      s2_sq_reg;
    logic [ABS_SUM_W-1:0] abs_sum_reg, abs_sum_next;
    logic [SQ_SUM_W-1:0]  sq_sum_reg, sq_sum_next;
    logic [ABS_W-1:0]     max_abs_reg, max_abs_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 accept;
    logic [ELEM_W:0]      diff;
    logic [ELEM_W:0]      diff_neg;
    logic [ABS_SUM_W:0]   abs_wide;
    logic [SQ_SUM_W:0]    sq_wide;

    assign s_tready = q_stat.room;
    assign accept   = s_tvalid && s_tready;

    assign diff     = {s_tdata[ELEM_W-1], s_tdata[ELEM_W-1:0]}
                    - {s_tdata[2*ELEM_W-1], s_tdata[2*ELEM_W-1:ELEM_W]};
    assign diff_neg = -diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
        s1_abs_reg  <= diff[ELEM_W] ? diff_neg[ABS_W-1:0] : diff[ABS_W-1:0];
        s1_last_reg <= s_tlast;
        s2_abs_reg  <= s1_abs_reg;
        s2_last_reg <= s1_last_reg;
        s2_sq_reg   <= SQ_W'(s1_abs_reg) * SQ_W'(s1_abs_reg);
    end

    always_comb begin
        abs_wide     = {1'b0, abs_sum_reg} + (ABS_SUM_W+1)'(s2_abs_reg);
        sq_wide      = {1'b0, sq_sum_reg} + (SQ_SUM_W+1)'(s2_sq_reg);
        abs_sum_next = abs_wide[ABS_SUM_W] ? '1 : abs_wide[ABS_SUM_W-1:0];
        sq_sum_next  = sq_wide[SQ_SUM_W] ? '1 : sq_wide[SQ_SUM_W-1:0];
        max_abs_next = (s2_abs_reg > max_abs_reg) ? s2_abs_reg : max_abs_reg;
        cnt_next     = (cnt_reg < COUNT_CAP) ? cnt_reg + 1'b1 : cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_sum_reg <= '0;
            sq_sum_reg  <= '0;
            max_abs_reg <= '0;
            cnt_reg     <= '0;
        end else if (s2_valid_reg) begin
            if (s2_last_reg) begin
                abs_sum_reg <= '0;
                sq_sum_reg  <= '0;
                max_abs_reg <= '0;
                cnt_reg     <= '0;
            end else begin
                abs_sum_reg <= abs_sum_next;
                sq_sum_reg  <= sq_sum_next;
                max_abs_reg <= max_abs_next;
                cnt_reg     <= cnt_next;
            end
        end
    end

    assign push = s2_valid_reg && s2_last_reg;

    always_comb begin
        push_job.is_root = 1'b0;
        push_job.count   = cnt_next;
        unique case (norm_select)
            NORM_L1: push_job.operand = OPND_W'(abs_sum_next);
            NORM_L2: begin
                push_job.is_root = 1'b1;
                push_job.operand = sq_sum_next;
            end
            default: push_job.operand = OPND_W'(max_abs_next);
        endcase
    end

endmodule

// ===== hw/rtl/vdn_queue.sv =====
// Short job queue between front and back end.
// Uses vdn_pkg for the job type and depth.
module vdn_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  vdn_pkg::job_t     push_job,
    input  logic              pop,
    output vdn_pkg::job_t     pop_job,
    output vdn_pkg::q_stat_t  q_stat
);
    import vdn_pkg::*;

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_job      = mem[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.room  = (count_reg <= QROOM_MAX);
    assign q_stat.count = count_reg;

endmodule

// ===== hw/rtl/vdn_back.sv =====
// Back end: takes jobs from the queue, runs the bit-serial square root for
// L2 jobs and holds the result in the output register. Uses vdn_pkg.
module vdn_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vdn_pkg::q_stat_t              q_stat,
    input  vdn_pkg::job_t                 pop_job,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vdn_pkg::M_TDATA_W-1:0] m_tdata
);
    import vdn_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROOT = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [OPND_W-1:0]   rem_reg, rem_next;
    logic [OPND_W-1:0]   res_reg, res_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [CNT_W-1:0]    root_cnt_reg, root_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                out_free;
    logic [OPND_W-1:0]   trial;

    assign out_free = !out_valid_reg || m_tready;
    assign trial    = res_reg + OPND_W'(bit_reg);

    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        root_cnt_next  = root_cnt_reg;
        dist_next      = dist_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    if (pop_job.is_root) begin
                        pop           = 1'b1;
                        rem_next      = pop_job.operand;
                        res_next      = '0;
                        bit_next      = {1'b1, {(BIT_W-1){1'b0}}};
                        root_cnt_next = pop_job.count;
                        state_next    = ST_ROOT;
                    end else if (out_free) begin
                        pop            = 1'b1;
                        dist_next      = pop_job.operand[DIST_W-1:0];
                        cnt_next       = pop_job.count;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_ROOT: begin
                // one result bit per cycle
                if (rem_reg >= trial) begin
                    rem_next = rem_reg - trial;
                    res_next = (res_reg >> 1) + OPND_W'(bit_reg);
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    dist_next      = res_reg[DIST_W-1:0];
                    cnt_next       = root_cnt_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        rem_reg      <= rem_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        root_cnt_reg <= root_cnt_next;
        dist_reg     <= dist_next;
        cnt_reg      <= cnt_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W-DIST_W-CNT_W)'(0), cnt_reg, dist_reg};

endmodule

// ===== hw/rtl/vector_distance_norm.sv =====
// Top level of the streaming L1 / L2 / L-infinity vector distance block.
// Instantiates vdn_front, vdn_queue and vdn_back; uses vdn_pkg.
//
// Usage:
//   s_ channel: one element pair per transfer, x and y in signed Q8.8;
//   s_tlast marks the final pair of a vector. m_ channel: one result per
//   vector, the selected distance in unsigned Q16.8 plus the pair count
//   (saturated at 256). cfg_wr_en / cfg_wr_data write the norm select
//   (0 = L1, 1 = L2, 2 = L-infinity); code 3 is ignored. Write it only
//   while no vector is in flight.
// Throughput: one pair per cycle while s_tready is high. A pair passes the
//   s1 and s2 registers of the front pipeline before it reaches the accumulators.
// Path from the last pair to m_tvalid: s1, s2, job queue, output register
//   for L1 and L-infinity; L2 jobs pass the square root unit first, which
//   resolves one result bit per cycle and takes no new job until it is
//   done. Back-to-back short L2 vectors are thus limited by the root unit.
// Stall: up to four finished vectors wait in the job queue; s_tready drops
//   when fewer than three slots are free. m_tdata holds while m_tready is low.
// Reset: clears the accumulators, the queue, the output valid flag and sets
//   the norm select to L1.
module vector_distance_norm (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_wr_data,  // norm_select
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vdn_pkg::S_TDATA_W-1:0] s_tdata,      // x_value[15:0], y_value[31:16]
    input  logic                          s_tlast,      // last_element
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vdn_pkg::M_TDATA_W-1:0] m_tdata       // distance[23:0], element_count[32:24]
);
    import vdn_pkg::*;

    logic [1:0] norm_select_reg;
    logic       push, pop;
    job_t       push_job, pop_job;
    q_stat_t    q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_select_reg <= NORM_L1;
        end else if (cfg_wr_en && cfg_wr_data != NORM_RSVD) begin
            norm_select_reg <= cfg_wr_data;
        end
    end

    vdn_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .norm_select (norm_select_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_stat      (q_stat),
        .push        (push),
        .push_job    (push_job)
    );

    vdn_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    vdn_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_stat.count != QCNT_W'(QDEPTH)) || pop)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("job queue underflow");

    a_norm_code: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_select_reg != NORM_RSVD)
        else $error("reserved norm code latched");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DIST_W +: CNT_W] != '0))
        else $error("result with zero element count");

endmodule
